### design/pdsp_pkg.sv
// Shared types and constants for the poke database stream parser.
package pdsp_pkg;

  localparam int COUNT_BITS = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } pdsp_in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] token_value;
    logic [31:0] game_number;
    logic [31:0] poke_number;
    logic        database_done;
  } pdsp_out_t;

  typedef enum logic [4:0] {
    TK_HEADER_OK      = 5'd0,
    TK_BAD_MAGIC      = 5'd1,
    TK_GAME_COUNT     = 5'd2,
    TK_NAME_LENGTH    = 5'd3,
    TK_NAME_BYTE      = 5'd4,
    TK_ID_SIZE        = 5'd5,
    TK_POKE_COUNT     = 5'd6,
    TK_DESC_LENGTH    = 5'd7,
    TK_DESC_BYTE      = 5'd8,
    TK_COMMENT_LENGTH = 5'd9,
    TK_COMMENT_BYTE   = 5'd10,
    TK_DATA_TYPE      = 5'd11,
    TK_REVERSED       = 5'd12,
    TK_RAM_BANK       = 5'd13,
    TK_ENTRY_COUNT    = 5'd14,
    TK_ENTRY_BYTES    = 5'd15,
    TK_ENTRY_ADDRESS  = 5'd16,
    TK_POKE_WORD      = 5'd17,
    TK_BAD_COUNT      = 5'd18
  } token_kind_t;

  // Parse phases, one-hot; each low-byte phase sits just below its high-byte phase.
  typedef enum logic [22:0] {
    PH_MAGIC       = 23'h000001,
    PH_GAME_COUNT  = 23'h000002,
    PH_NAME_LEN    = 23'h000004,
    PH_NAME_BYTES  = 23'h000008,
    PH_ID_LO       = 23'h000010,
    PH_ID_HI       = 23'h000020,
    PH_ID_SKIP     = 23'h000040,
    PH_POKE_COUNT  = 23'h000080,
    PH_DESC_LEN    = 23'h000100,
    PH_DESC_BYTES  = 23'h000200,
    PH_COMM_LEN    = 23'h000400,
    PH_COMM_BYTES  = 23'h000800,
    PH_DATA_TYPE   = 23'h001000,
    PH_REVERSED    = 23'h002000,
    PH_RAM_BANK    = 23'h004000,
    PH_ENTRY_COUNT = 23'h008000,
    PH_ENT_N_LO    = 23'h010000,
    PH_ENT_N_HI    = 23'h020000,
    PH_ENT_A_LO    = 23'h040000,
    PH_ENT_A_HI    = 23'h080000,
    PH_WORD_LO     = 23'h100000,
    PH_WORD_HI     = 23'h200000,
    PH_DONE        = 23'h400000
  } phase_t;

  // Byte classification passed from the front end to the parser.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       cont;
    logic       sign;
    logic [6:0] payload;
    logic       is_rev_char;
  } pdsp_cls_t;

  localparam logic [31:0] MAGIC_TEXT = 32'h4B4F5057; // bytes W,P,O,K from low
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [33:0] ACC_ONES   = '1;

endpackage

### design/pdsp_front.sv
// Front end: accepts bytes, classifies them and queues them for the parser.
module pdsp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdsp_pkg::pdsp_in_t  in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output pdsp_pkg::pdsp_cls_t q_data
);
  import pdsp_pkg::*;

  pdsp_cls_t  mem_r [QUEUE_DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  pdsp_cls_t  cls;
  logic       push, pop;

  // Split the byte into the fields the number decoder needs.
  always_comb begin
    cls.data_byte   = in_data.data_byte;
    cls.restart     = in_data.start_of_image;
    cls.cont        = in_data.data_byte[7];
    cls.sign        = in_data.data_byte[6];
    cls.payload     = in_data.data_byte[6:0];
    cls.is_rev_char = (in_data.data_byte == ASCII_ZERO);
  end

  assign in_ready = (cnt_r != 2'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  // Two-entry word queue.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= cls;
  end
endmodule

### design/pdsp_parse.sv
// Back end: walks the nested database structure and emits tokens.
module pdsp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  pdsp_pkg::pdsp_cls_t q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pdsp_pkg::pdsp_out_t out_data
);
  import pdsp_pkg::*;

  phase_t      ph_r, ph_nxt;
  logic [1:0]  mpos_r, mpos_nxt;
  logic        mmis_r, mmis_nxt;
  logic [33:0] acc_r, acc_nxt;
  logic [4:0]  sh_r, sh_nxt;
  logic        neg_r, neg_nxt;
  logic [7:0]  wlo_r, wlo_nxt;
  logic [31:0] games_r, games_nxt, pokes_r, pokes_nxt, ents_r, ents_nxt;
  logic [31:0] skip_r, skip_nxt, gc_r, gc_nxt, pc_r, pc_nxt;
  logic [15:0] pw_r, pw_nxt;
  logic        halt_r, halt_nxt;
  logic        ov_r, ov_nxt;
  pdsp_out_t   od_r, od_nxt;

  logic        go;
  logic [7:0]  b;
  logic [33:0] nacc;
  logic [15:0] w;
  logic        is_num, emit;
  logic [31:0] rg, rp;
  logic        rd;
  logic [4:0]  rk;
  logic [31:0] rv;

  assign q_ready  = !ov_r || out_ready;
  assign go       = q_valid && q_ready;
  assign b        = q_data.data_byte;
  assign w        = {b, wlo_r};
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // One byte of parsing per accepted word.
  always_comb begin
    phase_t p0;
    logic   hlt0;
    logic   end_g, end_p, end_e;
    p0 = ph_r; hlt0 = halt_r;
    mpos_nxt = mpos_r; mmis_nxt = mmis_r; acc_nxt = acc_r; sh_nxt = sh_r;
    neg_nxt = neg_r; wlo_nxt = wlo_r; games_nxt = games_r; pokes_nxt = pokes_r;
    ents_nxt = ents_r; skip_nxt = skip_r; gc_nxt = gc_r; pc_nxt = pc_r;
    pw_nxt = pw_r; halt_nxt = halt_r; ph_nxt = ph_r;
    emit = 1'b0; rk = TK_HEADER_OK; rv = '0; rg = gc_r; rp = pc_r; rd = 1'b0;
    end_g = 1'b0; end_p = 1'b0; end_e = 1'b0; nacc = '0;
    if (go && q_data.restart) begin
      p0 = PH_MAGIC; hlt0 = 1'b0; mpos_nxt = '0; mmis_nxt = 1'b0;
      acc_nxt = '0; sh_nxt = '0; neg_nxt = 1'b0; wlo_nxt = '0; games_nxt = '0;
      pokes_nxt = '0; ents_nxt = '0; skip_nxt = '0; gc_nxt = '0; pc_nxt = '0;
      pw_nxt = '0; halt_nxt = 1'b0; ph_nxt = PH_MAGIC;
      rg = '0; rp = '0;
    end
    is_num = (p0 == PH_GAME_COUNT) || (p0 == PH_NAME_LEN) || (p0 == PH_POKE_COUNT)
          || (p0 == PH_DESC_LEN) || (p0 == PH_COMM_LEN) || (p0 == PH_ENTRY_COUNT);
    if (go && !hlt0 && p0 != PH_DONE) begin
      // Variable-length number accumulation.
      if (is_num) begin
        if (sh_nxt == 5'd0) begin
          nacc = {28'd0, b[5:0]};
          neg_nxt = q_data.sign;
          sh_nxt = 5'd6;
        end else if (sh_nxt >= 5'd31) begin
          nacc = (q_data.payload != 7'd0) ? ACC_ONES : acc_nxt;
        end else begin
          nacc = acc_nxt | (34'(q_data.payload) << sh_nxt);
          sh_nxt = (sh_nxt > 5'd20) ? 5'd31 : sh_nxt + 5'd7;
        end
        acc_nxt = nacc;
      end
      if (is_num && q_data.cont) begin
        // more bytes follow
      end else if (is_num && (((neg_nxt && nacc != '0))
                   || (nacc > 34'((35'd1 << COUNT_BITS) - 35'd1)))) begin
        acc_nxt = '0; sh_nxt = '0; neg_nxt = 1'b0;
        halt_nxt = 1'b1; emit = 1'b1; rk = TK_BAD_COUNT; rv = nacc[31:0];
      end else begin
        if (is_num) begin
          acc_nxt = '0; sh_nxt = '0; neg_nxt = 1'b0;
        end
        case (p0)
          PH_MAGIC: begin
            if (b != MAGIC_TEXT[8*mpos_nxt +: 8]) mmis_nxt = 1'b1;
            if (mpos_nxt != 2'd3) mpos_nxt = mpos_nxt + 2'd1;
            else begin
              mpos_nxt = '0; emit = 1'b1;
              if (mmis_nxt) begin halt_nxt = 1'b1; rk = TK_BAD_MAGIC; end
              else begin ph_nxt = PH_GAME_COUNT; rk = TK_HEADER_OK; end
            end
          end
          PH_GAME_COUNT: begin
            games_nxt = nacc[31:0]; emit = 1'b1; rk = TK_GAME_COUNT; rv = nacc[31:0];
            if (nacc == '0) begin ph_nxt = PH_DONE; rd = 1'b1; end
            else ph_nxt = PH_NAME_LEN;
          end
          PH_NAME_LEN, PH_DESC_LEN, PH_COMM_LEN: begin
            skip_nxt = nacc[31:0]; emit = 1'b1; rv = nacc[31:0];
            case (p0)
              PH_NAME_LEN: begin rk = TK_NAME_LENGTH;
                ph_nxt = (nacc != '0) ? PH_NAME_BYTES : PH_ID_LO; end
              PH_DESC_LEN: begin rk = TK_DESC_LENGTH;
                ph_nxt = (nacc != '0) ? PH_DESC_BYTES : PH_COMM_LEN; end
              default: begin rk = TK_COMMENT_LENGTH;
                ph_nxt = (nacc != '0) ? PH_COMM_BYTES : PH_DATA_TYPE; end
            endcase
          end
          PH_NAME_BYTES, PH_DESC_BYTES, PH_COMM_BYTES: begin
            skip_nxt = skip_nxt - 32'd1; emit = 1'b1; rv = {24'd0, b};
            case (p0)
              PH_NAME_BYTES: begin rk = TK_NAME_BYTE;
                if (skip_nxt == '0) ph_nxt = PH_ID_LO; end
              PH_DESC_BYTES: begin rk = TK_DESC_BYTE;
                if (skip_nxt == '0) ph_nxt = PH_COMM_LEN; end
              default: begin rk = TK_COMMENT_BYTE;
                if (skip_nxt == '0) ph_nxt = PH_DATA_TYPE; end
            endcase
          end
          PH_ID_LO, PH_ENT_N_LO, PH_ENT_A_LO, PH_WORD_LO: begin
            // The high-byte phase is the next bit up.
            wlo_nxt = b; ph_nxt = phase_t'(p0 << 1);
          end
          PH_ID_HI: begin
            emit = 1'b1; rk = TK_ID_SIZE; rv = {16'd0, w};
            if (w != 16'd0) begin
              skip_nxt = {16'd0, w} + 32'd2; ph_nxt = PH_ID_SKIP;
            end else ph_nxt = PH_POKE_COUNT;
          end
          PH_ID_SKIP: begin
            skip_nxt = skip_nxt - 32'd1;
            if (skip_nxt == '0) ph_nxt = PH_POKE_COUNT;
          end
          PH_POKE_COUNT: begin
            pokes_nxt = nacc[31:0]; pc_nxt = '0; rp = '0;
            emit = 1'b1; rk = TK_POKE_COUNT; rv = nacc[31:0];
            if (nacc == '0) end_g = 1'b1; else ph_nxt = PH_DESC_LEN;
          end
          PH_DATA_TYPE: begin
            emit = 1'b1; rk = TK_DATA_TYPE; rv = {24'd0, b}; ph_nxt = PH_REVERSED;
          end
          PH_REVERSED: begin
            emit = 1'b1; rk = TK_REVERSED; rv = {31'd0, q_data.is_rev_char};
            ph_nxt = PH_RAM_BANK;
          end
          PH_RAM_BANK: begin
            emit = 1'b1; rk = TK_RAM_BANK; rv = {24'd0, b}; ph_nxt = PH_ENTRY_COUNT;
          end
          PH_ENTRY_COUNT: begin
            ents_nxt = nacc[31:0]; emit = 1'b1; rk = TK_ENTRY_COUNT; rv = nacc[31:0];
            if (nacc == '0) end_p = 1'b1; else ph_nxt = PH_ENT_N_LO;
          end
          PH_ENT_N_HI: begin
            pw_nxt = w; emit = 1'b1; rk = TK_ENTRY_BYTES; rv = {16'd0, w};
            ph_nxt = PH_ENT_A_LO;
          end
          PH_ENT_A_HI: begin
            emit = 1'b1; rk = TK_ENTRY_ADDRESS; rv = {16'd0, w};
            if (pw_nxt == '0) end_e = 1'b1; else ph_nxt = PH_WORD_LO;
          end
          PH_WORD_HI: begin
            emit = 1'b1; rk = TK_POKE_WORD; rv = {16'd0, w};
            pw_nxt = pw_nxt - 16'd1;
            if (pw_nxt == '0) end_e = 1'b1; else ph_nxt = PH_WORD_LO;
          end
          default: ;
        endcase
        // Close nested levels: entry, then poke, then game.
        if (end_e) begin
          ents_nxt = ents_nxt - 32'd1;
          if (ents_nxt == '0) end_p = 1'b1; else ph_nxt = PH_ENT_N_LO;
        end
        if (end_p) begin
          pokes_nxt = pokes_nxt - 32'd1;
          if (pokes_nxt == '0) end_g = 1'b1;
          else begin pc_nxt = pc_nxt + 32'd1; ph_nxt = PH_DESC_LEN; end
        end
        if (end_g) begin
          games_nxt = games_nxt - 32'd1; gc_nxt = gc_nxt + 32'd1; pc_nxt = '0;
          if (games_nxt == '0) begin ph_nxt = PH_DONE; rd = 1'b1; end
          else ph_nxt = PH_NAME_LEN;
        end
      end
    end
    od_nxt = od_r;
    ov_nxt = ov_r && !out_ready;
    if (go && emit) begin
      ov_nxt = 1'b1;
      od_nxt.token_kind = rk; od_nxt.token_value = rv;
      od_nxt.game_number = rg; od_nxt.poke_number = rp;
      od_nxt.database_done = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_MAGIC; mpos_r <= '0; mmis_r <= 1'b0; acc_r <= '0; sh_r <= '0;
      neg_r <= 1'b0; wlo_r <= '0; games_r <= '0; pokes_r <= '0; ents_r <= '0;
      skip_r <= '0; gc_r <= '0; pc_r <= '0; pw_r <= '0; halt_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; mpos_r <= mpos_nxt; mmis_r <= mmis_nxt; acc_r <= acc_nxt;
      sh_r <= sh_nxt; neg_r <= neg_nxt; wlo_r <= wlo_nxt; games_r <= games_nxt;
      pokes_r <= pokes_nxt; ents_r <= ents_nxt; skip_r <= skip_nxt;
      gc_r <= gc_nxt; pc_r <= pc_nxt; pw_r <= pw_nxt; halt_r <= halt_nxt;
      ov_r <= ov_nxt;
    end
    od_r <= od_nxt;
  end
endmodule

### design/poke_database_stream_parser.sv
// Top level of the poke database stream parser.
// Usage: feed one image byte per word on the in_ channel; set
// start_of_image on the first byte of each image to restart parsing.
// The out_ channel carries at most one token per byte: a kind, a value
// and the game and poke indices it belongs to, plus database_done.
// Both channels use valid/ready and a word moves when both are high.
// Throughput is one byte per cycle while the receiver takes tokens; a
// stalled token register holds the queue. An accepted byte is written
// into the two-entry front queue, then its token into the token register.
// After reset the parser expects the magic, as if a start was marked.
// When the receiver stalls, the token register holds and the queue
// fills; in_ready drops once both queue entries are occupied.
// Bytes after a halt or a finished database give no tokens.
module poke_database_stream_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdsp_pkg::pdsp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pdsp_pkg::pdsp_out_t out_data
);
  import pdsp_pkg::*;

  logic      q_valid, q_ready;
  pdsp_cls_t q_data;

  // Front end with its queue.
  pdsp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  // Parser back end.
  pdsp_parse u_parse (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );

  // A stalled token stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("token changed while stalled");

  // The parser only drains the queue when the token slot is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !q_ready)
    else $error("queue popped with token slot full");

  // The queue never refuses bytes while it is empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> in_ready)
    else $error("empty queue not ready");
endmodule
